// File: hdl/pts_pkg.sv
package pts_pkg;

    localparam int unsigned DEPTH = 1024;
    localparam int unsigned AW    = 10;
    localparam int unsigned CW    = 11;

    typedef logic [1:0] t_trit;
    typedef logic [2:0] t_cmd;

    localparam t_trit TRIT_UNK   = 2'd0;
    localparam t_trit TRIT_TRUE  = 2'd1;
    localparam t_trit TRIT_FALSE = 2'd2;
    localparam t_trit TRIT_BAD   = 2'd3;

    localparam t_cmd CMD_READ   = 3'd0;
    localparam t_cmd CMD_WRITE  = 3'd1;
    localparam t_cmd CMD_AND    = 3'd2;
    localparam t_cmd CMD_OR     = 3'd3;
    localparam t_cmd CMD_NOT    = 3'd4;
    localparam t_cmd CMD_SHRINK = 3'd5;
    localparam t_cmd CMD_TRIM   = 3'd6;

    typedef struct packed {
        logic          we;
        logic [AW-1:0] waddr;
        t_trit         wdata;
        logic          re;
        logic [AW-1:0] raddr;
    } t_ram_req;

    function automatic t_trit kl_and(t_trit a, t_trit b);
        t_trit r;
        if (a == TRIT_FALSE || b == TRIT_FALSE) begin
            r = TRIT_FALSE;
        end else if (a == TRIT_TRUE && b == TRIT_TRUE) begin
            r = TRIT_TRUE;
        end else begin
            r = TRIT_UNK;
        end
        return r;
    endfunction

    function automatic t_trit kl_or(t_trit a, t_trit b);
        t_trit r;
        if (a == TRIT_TRUE || b == TRIT_TRUE) begin
            r = TRIT_TRUE;
        end else if (a == TRIT_FALSE && b == TRIT_FALSE) begin
            r = TRIT_FALSE;
        end else begin
            r = TRIT_UNK;
        end
        return r;
    endfunction

    function automatic t_trit kl_not(t_trit a);
        t_trit r;
        if (a == TRIT_TRUE) begin
            r = TRIT_FALSE;
        end else if (a == TRIT_FALSE) begin
            r = TRIT_TRUE;
        end else begin
            r = TRIT_UNK;
        end
        return r;
    endfunction

endpackage

// File: hdl/pts_ram.sv
module pts_ram
    import pts_pkg::*;
(
    input  logic     i_clk,
    input  t_ram_req i_req,
    output t_trit    o_rdata
);

    t_trit r_mem [DEPTH];
    t_trit r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_req.we) begin
            r_mem[i_req.waddr] <= i_req.wdata;
        end
        if (i_req.re) begin
            r_rdata <= r_mem[i_req.raddr];
        end
    end

    assign o_rdata = r_rdata;

endmodule

// File: hdl/packed_trit_store_kleene.sv
// Read, write, and, or, not pass through EXEC, then FIN, from request accept to result register.
// A new request is accepted only in IDLE, once the previous one has reached the result register.
// Shrink and trim pass through S_CUT_RD, then S_CUT_WR, per dropped entry (read, then clear of each entry).
// Clearing a known trit at the top of the set adds S_LEN_RD, then S_LEN_CHK, per entry scanned downward.
// Reset: synchronous; a clearing pass over all 1024 entries follows, with s_axis_tready low.
module packed_trit_store_kleene
    import pts_pkg::*;
(
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    input  logic [15:0] s_axis_tdata,  // command[2:0], index[12:3], value[14:13], zero
    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    output logic [63:0] m_axis_tdata,  // trit[1:0], count_true[12:2], count_false[23:13],
                                       // count_unknown[34:24], length[45:35],
                                       // capacity[56:46], zero
    output logic        m_axis_tuser   // status
);

    localparam logic [2:0] S_CLR     = 3'd0;
    localparam logic [2:0] S_IDLE    = 3'd1;
    localparam logic [2:0] S_EXEC    = 3'd2;
    localparam logic [2:0] S_CUT_RD  = 3'd3;
    localparam logic [2:0] S_CUT_WR  = 3'd4;
    localparam logic [2:0] S_LEN_RD  = 3'd5;
    localparam logic [2:0] S_LEN_CHK = 3'd6;
    localparam logic [2:0] S_FIN     = 3'd7;

    logic [2:0]    r_state, n_state;
    logic [AW-1:0] r_clr, n_clr;
    logic [CW-1:0] r_cap, n_cap;
    logic [AW-1:0] r_last, n_last;
    logic [CW-1:0] r_true, n_true;
    logic [CW-1:0] r_false, n_false;
    logic [CW-1:0] r_len, n_len;
    logic          r_ovalid, n_ovalid;

    t_cmd          r_cmd, n_cmd;
    logic [AW-1:0] r_idx, n_idx;
    t_trit         r_val, n_val;
    logic [CW-1:0] r_tgt, n_tgt;
    t_trit         r_trit, n_trit;
    logic          r_status, n_status;
    logic [63:0]   r_odata, n_odata;
    logic          r_ouser, n_ouser;

    t_ram_req      ram_req;
    t_trit         rd_data;

    t_cmd          in_cmd;
    logic [AW-1:0] in_idx;
    t_trit         in_val;
    logic [CW-1:0] idx_ext;
    logic [CW-1:0] idx_inc;
    logic          in_cap;
    t_trit         old_in;
    t_trit         sv;
    logic [CW-1:0] cut_tgt;
    logic [CW-1:0] cap_dec;
    logic [CW-1:0] unk_cnt;

    assign in_cmd  = s_axis_tdata[2:0];
    assign in_idx  = s_axis_tdata[12:3];
    assign in_val  = s_axis_tdata[14:13];
    assign idx_ext = {1'b0, r_idx};
    assign idx_inc = idx_ext + CW'(1);
    assign in_cap  = idx_ext < r_cap;
    assign old_in  = in_cap ? rd_data : TRIT_UNK;
    assign cap_dec = r_cap - CW'(1);
    assign unk_cnt = r_cap - r_true - r_false;
    assign cut_tgt = (r_cmd == CMD_SHRINK) ? ({1'b0, r_last} + CW'(1)) : idx_inc;

    always_comb begin
        if (r_cmd == CMD_WRITE || !in_cap) begin
            sv = r_val;
        end else if (r_cmd == CMD_AND) begin
            sv = kl_and(rd_data, r_val);
        end else begin
            sv = kl_or(rd_data, r_val);
        end
    end

    assign s_axis_tready = (r_state == S_IDLE);

    always_comb begin
        n_state  = r_state;
        n_clr    = r_clr;
        n_cap    = r_cap;
        n_last   = r_last;
        n_true   = r_true;
        n_false  = r_false;
        n_len    = r_len;
        n_ovalid = r_ovalid;
        n_cmd    = r_cmd;
        n_idx    = r_idx;
        n_val    = r_val;
        n_tgt    = r_tgt;
        n_trit   = r_trit;
        n_status = r_status;
        n_odata  = r_odata;
        n_ouser  = r_ouser;
        ram_req  = '0;

        if (r_ovalid && m_axis_tready) begin
            n_ovalid = 1'b0;
        end

        unique case (r_state)
            S_CLR: begin
                ram_req.we    = 1'b1;
                ram_req.waddr = r_clr;
                ram_req.wdata = TRIT_UNK;
                n_clr         = r_clr + AW'(1);
                if (r_clr == AW'(DEPTH - 1)) begin
                    n_state = S_IDLE;
                end
            end
            S_IDLE: begin
                if (s_axis_tvalid) begin
                    n_cmd         = in_cmd;
                    n_idx         = in_idx;
                    n_val         = (in_val == TRIT_BAD) ? TRIT_UNK : in_val;
                    ram_req.re    = 1'b1;
                    ram_req.raddr = in_idx;
                    n_state       = S_EXEC;
                end
            end
            S_EXEC: begin
                n_status = 1'b0;
                n_trit   = old_in;
                n_state  = S_FIN;
                unique case (r_cmd)
                    CMD_READ: begin
                        n_status = !in_cap;
                    end
                    CMD_WRITE, CMD_AND, CMD_OR: begin
                        if (in_cap || sv != TRIT_UNK) begin
                            ram_req.we    = 1'b1;
                            ram_req.waddr = r_idx;
                            ram_req.wdata = sv;
                            n_true  = r_true - CW'(old_in == TRIT_TRUE)
                                      + CW'(sv == TRIT_TRUE);
                            n_false = r_false - CW'(old_in == TRIT_FALSE)
                                      + CW'(sv == TRIT_FALSE);
                            n_cap   = in_cap ? r_cap : idx_inc;
                            n_last  = r_idx;
                            n_trit  = sv;
                            if (sv != TRIT_UNK) begin
                                if (idx_inc > r_len) begin
                                    n_len = idx_inc;
                                end
                            end else if (idx_inc == r_len) begin
                                n_len   = idx_ext;
                                n_state = S_LEN_RD;
                            end
                        end
                    end
                    CMD_NOT: begin
                        if (in_cap) begin
                            ram_req.we    = 1'b1;
                            ram_req.waddr = r_idx;
                            ram_req.wdata = kl_not(rd_data);
                            n_true        = r_true - CW'(rd_data == TRIT_TRUE)
                                            + CW'(rd_data == TRIT_FALSE);
                            n_false       = r_false - CW'(rd_data == TRIT_FALSE)
                                            + CW'(rd_data == TRIT_TRUE);
                            n_trit        = kl_not(rd_data);
                        end else begin
                            n_status = 1'b1;
                        end
                    end
                    CMD_SHRINK, CMD_TRIM: begin
                        n_tgt  = cut_tgt;
                        n_trit = (in_cap && idx_ext < cut_tgt) ? rd_data : TRIT_UNK;
                        if (cut_tgt < r_cap) begin
                            n_state = S_CUT_RD;
                        end
                    end
                    default: begin
                    end
                endcase
            end
            S_CUT_RD: begin
                ram_req.re    = 1'b1;
                ram_req.raddr = cap_dec[AW-1:0];
                n_state       = S_CUT_WR;
            end
            S_CUT_WR: begin
                ram_req.we    = 1'b1;
                ram_req.waddr = cap_dec[AW-1:0];
                ram_req.wdata = TRIT_UNK;
                n_true        = r_true - CW'(rd_data == TRIT_TRUE);
                n_false       = r_false - CW'(rd_data == TRIT_FALSE);
                n_cap         = cap_dec;
                if (cap_dec == r_tgt) begin
                    if (r_len > r_tgt) begin
                        n_len   = r_tgt;
                        n_state = S_LEN_RD;
                    end else begin
                        n_state = S_FIN;
                    end
                end else begin
                    n_state = S_CUT_RD;
                end
            end
            S_LEN_RD: begin
                if (r_len == '0) begin
                    n_state = S_FIN;
                end else begin
                    ram_req.re    = 1'b1;
                    ram_req.raddr = AW'(r_len - CW'(1));
                    n_state       = S_LEN_CHK;
                end
            end
            S_LEN_CHK: begin
                if (rd_data != TRIT_UNK) begin
                    n_state = S_FIN;
                end else begin
                    n_len   = r_len - CW'(1);
                    n_state = S_LEN_RD;
                end
            end
            S_FIN: begin
                if (!r_ovalid || m_axis_tready) begin
                    n_ovalid = 1'b1;
                    n_odata  = {7'd0, r_cap, r_len, unk_cnt, r_false, r_true, r_trit};
                    n_ouser  = r_status;
                    n_state  = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state  <= S_CLR;
            r_clr    <= '0;
            r_cap    <= '0;
            r_last   <= '0;
            r_true   <= '0;
            r_false  <= '0;
            r_len    <= '0;
            r_ovalid <= 1'b0;
        end else begin
            r_state  <= n_state;
            r_clr    <= n_clr;
            r_cap    <= n_cap;
            r_last   <= n_last;
            r_true   <= n_true;
            r_false  <= n_false;
            r_len    <= n_len;
            r_ovalid <= n_ovalid;
        end
    end

    always_ff @(posedge i_clk) begin
        r_cmd    <= n_cmd;
        r_idx    <= n_idx;
        r_val    <= n_val;
        r_tgt    <= n_tgt;
        r_trit   <= n_trit;
        r_status <= n_status;
        r_odata  <= n_odata;
        r_ouser  <= n_ouser;
    end

    pts_ram u_ram (
        .i_clk   (i_clk),
        .i_req   (ram_req),
        .o_rdata (rd_data)
    );

    assign m_axis_tvalid = r_ovalid;
    assign m_axis_tdata  = r_odata;
    assign m_axis_tuser  = r_ouser;

    a_counts_fit: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        ({1'b0, r_true} + {1'b0, r_false}) <= {1'b0, r_cap})
        else $error("true and false counts exceed capacity");

    a_len_fit: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_state == S_IDLE |-> r_len <= r_cap)
        else $error("length beyond capacity");

    a_accept_exec: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        s_axis_tvalid && s_axis_tready |=> r_state == S_EXEC)
        else $error("accepted request not executed");

    a_cut_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_state == S_CUT_WR |-> r_cap > r_tgt)
        else $error("cut sweep passed its target");

endmodule
